### sv/quadratic_root_solver_assert.svh
// Assertion macros used by the checker file of the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
// Property that must hold at every rising clock edge outside reset.
`define QRS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### sv/qrs_pkg.sv
// Package with the shared types and codes of the quadratic root solver.
package qrs_pkg;
	localparam int unsigned StatusWidth = 2;
	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_TWO = 2'd2,
		ST_DEGEN = 2'd3
	} status_t;
endpackage

### sv/quadratic_root_solver.sv
// Top level of the quadratic root solver: front part, queue and back part.
// Stages: front stages s1 and s2, the queue, then COEFF_WIDTH+1 square root
// stages, one set-up stage, COEFF_WIDTH+FRAC_BITS+3 division stages and one
// output register.
// Throughput: one item per cycle unless stalled; each part has its own stall.
// Reset clears all valid flags asynchronously; payload registers are not reset.
module quadratic_root_solver #(
	parameter int unsigned COEFF_WIDTH = 32,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COEFF_WIDTH-1:0]  coeff_a,
	input  logic signed [COEFF_WIDTH-1:0]  coeff_b,
	input  logic signed [COEFF_WIDTH-1:0]  coeff_c,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COEFF_WIDTH-1:0]  root_low,
	output logic signed [COEFF_WIDTH-1:0]  root_high,
	output logic [qrs_pkg::StatusWidth-1:0] root_status,
	output logic                           saturated
);
	import qrs_pkg::*;
	localparam int unsigned PW = 5*COEFF_WIDTH + 7;

	// Hand-off between the front and the queue, and between the queue and the back.
	logic f_valid, f_ready, b_valid, b_ready;
	logic [PW-1:0] f_data, b_data;
	status_t st;

	// The front part classifies each item and forms its discriminant.
	qrs_front #(.W(COEFF_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a(coeff_a), .b(coeff_b), .c(coeff_c),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
	);

	// A short queue lets the two parts stall independently.
	qrs_fifo #(.WIDTH(PW), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	// The back part computes the roots with pipelined root and divide stages.
	qrs_back #(.W(COEFF_WIDTH), .F(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.root_low(root_low), .root_high(root_high),
		.root_status(st), .saturated(saturated)
	);

	assign root_status = st;
endmodule

### sv/qrs_fifo.sv
// Short queue that decouples the front part from the back part.
module qrs_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH)) || out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end
endmodule

### sv/qrs_front.sv
// Front part: splits coefficients into sign and magnitude and forms the discriminant.
module qrs_front #(
	parameter int unsigned W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [W-1:0]  a,
	input  logic signed [W-1:0]  b,
	input  logic signed [W-1:0]  c,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [5*W+6:0]       out_data
);
	import qrs_pkg::*;
	// out_data: {status, nb, na, nc, ma, mb, mc, d}
	logic v1_s1, v2_s2;
	logic na_s1, nb_s1, nc_s1;
	logic [W-1:0] ma_s1, mb_s1, mc_s1;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic na_s2, nb_s2, nc_s2;
	logic [W-1:0] ma_s2, mb_s2, mc_s2;
	logic adv;
	logic [2*W+1:0] ac4, dsum;
	logic neg_d;
	status_t st;

	assign adv = out_ready || !v2_s2;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= in_valid;
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s1 <= a[W-1];
			nb_s1 <= b[W-1];
			nc_s1 <= c[W-1];
			ma_s1 <= a[W-1] ? W'(-a) : W'(a);
			mb_s1 <= b[W-1] ? W'(-b) : W'(b);
			mc_s1 <= c[W-1] ? W'(-c) : W'(c);
			bb_s2 <= mb_s1 * mb_s1;
			ac_s2 <= ma_s1 * mc_s1;
			na_s2 <= na_s1;
			nb_s2 <= nb_s1;
			nc_s2 <= nc_s1;
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			mc_s2 <= mc_s1;
		end
	end

	always_comb begin
		ac4 = {ac_s2, 2'b00};
		neg_d = 1'b0;
		if (na_s2 != nc_s2) begin
			dsum = {2'b00, bb_s2} + ac4;
		end else begin
			neg_d = {2'b00, bb_s2} < ac4;
			dsum = {2'b00, bb_s2} - ac4;
		end
		if (ma_s2 == '0) begin
			st = ST_DEGEN;
		end else if (neg_d) begin
			st = ST_NONE;
		end else if (dsum == '0) begin
			st = ST_DOUBLE;
		end else begin
			st = ST_TWO;
		end
	end

	assign out_valid = v2_s2;
	assign out_data = {st, nb_s2, na_s2, nc_s2, ma_s2, mb_s2, mc_s2, dsum};
endmodule

### sv/qrs_back.sv
// Back part: square root, the two divisions and clamping, as a staged pipeline.
module qrs_back #(
	parameter int unsigned W = 32,
	parameter int unsigned F = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [5*W+6:0]       in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [W-1:0]  root_low,
	output logic signed [W-1:0]  root_high,
	output qrs_pkg::status_t     root_status,
	output logic                 saturated
);
	import qrs_pkg::*;
	localparam int unsigned DW = 2*W + 2;  // discriminant width
	localparam int unsigned SW = W + 1;    // square root width
	localparam int unsigned QW = W + 2;    // width of 2q and of divisors
	localparam int unsigned NW = QW + F + 1; // dividend width
	localparam int unsigned SQ = SW;       // square root stages
	localparam int unsigned DV = NW;       // division stages
	localparam int unsigned NS = SQ + 1 + DV + 1;

	typedef struct packed {
		status_t st;
		logic nb, na, nc;
		logic [W-1:0] ma, mb, mc;
	} info_t;

	logic adv;
	logic [NS-1:0] vld_q;

	// Square root: one result bit per stage.
	info_t inf_sq [SQ+1];
	logic [DW-1:0] rem_sq [SQ+1];
	logic [SW-1:0] rt_sq [SQ+1];

	// Division: two dividers, one quotient bit per stage.
	info_t inf_dv [DV+1];
	logic [NW-1:0] n0_dv [DV+1], n1_dv [DV+1], q0_dv [DV+1], q1_dv [DV+1];
	logic [QW:0] r0_dv [DV+1], r1_dv [DV+1];
	logic [QW-1:0] d0_dv [DV+1], d1_dv [DV+1];
	logic ng0_dv [DV+1], ng1_dv [DV+1];

	assign adv = out_ready || !vld_q[NS-1];
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	always_comb begin
		inf_sq[0] = info_t'(in_data[5*W+6:DW]);
		rem_sq[0] = in_data[DW-1:0];
		rt_sq[0] = '0;
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		localparam int unsigned BIT = SQ - 1 - i;
		logic [2*SW+1:0] t2, cur;
		logic [SW-1:0] t;
		always_comb begin
			t = rt_sq[i] | (SW'(1) << BIT);
			t2 = (2*SW+2)'(t) * (2*SW+2)'(t);
			cur = (2*SW+2)'(rem_sq[i]);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				inf_sq[i+1] <= inf_sq[i];
				rem_sq[i+1] <= rem_sq[i];
				rt_sq[i+1] <= (t2 <= cur) ? t : rt_sq[i];
			end
		end
	end

	// Set up the divisions.
	info_t inf_su;
	logic [QW-1:0] q2_su;
	always_ff @(posedge clk) begin
		if (adv) begin
			inf_su <= inf_sq[SQ];
			q2_su <= QW'(inf_sq[SQ].mb) + QW'(rt_sq[SQ]);
		end
	end

	always_comb begin
		inf_dv[0] = inf_su;
		r0_dv[0] = '0;
		r1_dv[0] = '0;
		q0_dv[0] = '0;
		q1_dv[0] = '0;
		d0_dv[0] = {1'b0, inf_su.ma, 1'b0};
		d1_dv[0] = q2_su;
		ng0_dv[0] = 1'b0;
		ng1_dv[0] = 1'b0;
		if (inf_su.st == ST_DOUBLE) begin
			n0_dv[0] = NW'(inf_su.mb) << F;
			ng0_dv[0] = (inf_su.mb != '0) && (inf_su.nb == inf_su.na);
			n1_dv[0] = '0;
			d1_dv[0] = QW'(1);
		end else begin
			n0_dv[0] = NW'(q2_su) << F;
			n1_dv[0] = NW'(inf_su.mc) << (F + 1);
			ng0_dv[0] = ((!inf_su.nb) && (inf_su.mb != '0)) != inf_su.na;
			ng1_dv[0] = ((!inf_su.nb) && (inf_su.mb != '0)) != inf_su.nc;
		end
		if (d1_dv[0] == '0) begin
			d1_dv[0] = QW'(1);
		end
	end

	for (genvar i = 0; i < DV; i++) begin : g_div
		localparam int unsigned BIT = DV - 1 - i;
		logic [QW:0] t0, t1;
		logic ge0, ge1;
		always_comb begin
			t0 = {r0_dv[i][QW-1:0], n0_dv[i][BIT]};
			t1 = {r1_dv[i][QW-1:0], n1_dv[i][BIT]};
			ge0 = t0 >= {1'b0, d0_dv[i]};
			ge1 = t1 >= {1'b0, d1_dv[i]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				inf_dv[i+1] <= inf_dv[i];
				n0_dv[i+1] <= n0_dv[i];
				n1_dv[i+1] <= n1_dv[i];
				d0_dv[i+1] <= d0_dv[i];
				d1_dv[i+1] <= d1_dv[i];
				ng0_dv[i+1] <= ng0_dv[i];
				ng1_dv[i+1] <= ng1_dv[i];
				r0_dv[i+1] <= ge0 ? t0 - {1'b0, d0_dv[i]} : t0;
				r1_dv[i+1] <= ge1 ? t1 - {1'b0, d1_dv[i]} : t1;
				q0_dv[i+1] <= q0_dv[i] | (ge0 ? (NW'(1) << BIT) : '0);
				q1_dv[i+1] <= q1_dv[i] | (ge1 ? (NW'(1) << BIT) : '0);
			end
		end
	end

	// Clamp, order and register the result.
	function automatic logic [W:0] clampf(input logic ng, input logic [NW-1:0] m);
		logic [NW-1:0] lim;
		logic [W-1:0] v;
		logic s;
		lim = (NW'(1) << (W - 1)) - NW'(!ng);
		s = m > lim;
		v = s ? W'(lim) : W'(m);
		if (v == '0) begin
			clampf = {s, {W{1'b0}}};
		end else begin
			clampf = {s, ng ? W'(-v) : v};
		end
	endfunction

	logic [W:0] c0, c1;
	info_t inf_f;
	always_comb begin
		inf_f = inf_dv[DV];
		c0 = clampf(ng0_dv[DV], q0_dv[DV]);
		c1 = clampf(ng1_dv[DV], q1_dv[DV]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_status <= inf_f.st;
			root_low <= '0;
			root_high <= '0;
			saturated <= 1'b0;
			case (inf_f.st)
				ST_DOUBLE: begin
					root_low <= c0[W-1:0];
					root_high <= c0[W-1:0];
					saturated <= c0[W];
				end
				ST_TWO: begin
					saturated <= c0[W] | c1[W];
					if ($signed(c1[W-1:0]) < $signed(c0[W-1:0])) begin
						root_low <= c1[W-1:0];
						root_high <= c0[W-1:0];
					end else begin
						root_low <= c0[W-1:0];
						root_high <= c1[W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = vld_q[NS-1];
endmodule

### sv/qrs_checker.sv
// Port checker for the quadratic root solver, bound to the top level.
`include "quadratic_root_solver_assert.svh"
module qrs_checker #(
	parameter int unsigned COEFF_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [COEFF_WIDTH-1:0] root_low,
	input logic [COEFF_WIDTH-1:0] root_high,
	input logic [1:0]             root_status,
	input logic                   saturated
);
	import qrs_pkg::*;
	`QRS_ASSERT_ALWAYS(a_order, clk, arst_n,
		!out_valid || ($signed(root_low) <= $signed(root_high)))
	`QRS_ASSERT_ALWAYS(a_none_zero, clk, arst_n,
		!out_valid || (root_status != ST_NONE && root_status != ST_DEGEN) ||
		(root_low == '0 && root_high == '0 && !saturated))
	`QRS_ASSERT_ALWAYS(a_double_eq, clk, arst_n,
		!out_valid || root_status != ST_DOUBLE || root_low == root_high)
	`QRS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(root_low) && $stable(root_status))
endmodule

bind quadratic_root_solver qrs_checker #(.COEFF_WIDTH(COEFF_WIDTH)) u_qrs_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.root_low(root_low), .root_high(root_high), .root_status(root_status),
	.saturated(saturated)
);
